// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TLG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TLG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tlg_pkg.sv =====
// Types, constants and helper functions for the toroidal life grid.
`timescale 1ns / 1ps

package tlg_pkg;

	// Stored grid size and derived index widths.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W    = $clog2(MAX_ROWS + 2);

	// Configuration register layout.
	localparam int SIZE_W   = 7;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam logic REG_ACTIVE_ROWS = 1'b0;
	localparam logic REG_ACTIVE_COLS = 1'b1;

	// Operation codes of an input command.
	typedef enum logic [1:0] {
		OP_QUERY   = 2'd0,
		OP_KILL    = 2'd1,
		OP_REVIVE  = 2'd2,
		OP_ADVANCE = 2'd3
	} op_t;

	// Command and result payloads.
	typedef struct packed {
		logic [1:0]        kind;
		logic signed [7:0] row;
		logic signed [7:0] col;
	} cmd_t;

	typedef struct packed {
		logic alive;
		logic invalid;
	} res_t;

	typedef logic [MAX_COLS-1:0] row_t;

	// Write request into the row memory.
	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] addr;
		row_t             data;
	} mem_wr_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_ADV
	} state_t;

	// A size of zero acts as one, a size above the maximum acts as the maximum.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== design/tlg_cell.sv =====
// One column cell: a three-row window of its column and the B3/S23 rule.
`timescale 1ns / 1ps

module tlg_cell
	import tlg_pkg::*;
(
	input  logic       clk,
	input  logic       shift,
	input  logic       d,
	input  logic [2:0] left_w,
	input  logic [2:0] right_w,
	output logic [2:0] win,
	output logic       nxt
);

	logic       up_q;
	logic       mid_q;
	logic [3:0] count;

	// The window moves down one row on every shift; the incoming bit is the lower row.
	always_ff @(posedge clk) begin
		if (shift) begin
			up_q  <= mid_q;
			mid_q <= d;
		end
	end

	// Window seen by the neighbors: upper row, middle row, lower row.
	assign win = {up_q, mid_q, d};

	// Eight neighbor positions: three from each side column, upper and lower of own column.
	always_comb begin
		count = 4'(left_w[0]) + 4'(left_w[1]) + 4'(left_w[2])
			+ 4'(right_w[0]) + 4'(right_w[1]) + 4'(right_w[2])
			+ 4'(up_q) + 4'(d);
		nxt = (count == 4'd3) || (mid_q && (count == 4'd2));
	end

endmodule

// ===== design/tlg_row_mem.sv =====
// Row memory of the grid, with per-row valid bits so unwritten rows read as dead.
`timescale 1ns / 1ps

module tlg_row_mem
	import tlg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] rd_addr,
	input  mem_wr_t          wr,
	output row_t             rd_data
);

	row_t                mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] valid_q;
	row_t                rdata_q;
	logic                rvalid_q;

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Valid bits mark rows written since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rvalid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

// ===== design/toroidal_life_grid_top.sv =====
// Top level of the toroidal life grid: controller, configuration port, cells and memory.
//
// Commands enter on in_item and are transferred at a rising edge with start high and
// busy low. Each command gives one result on result, marked by done for one cycle;
// the receiver must take it then, as it cannot hold results off.
// Query, kill and revive in range: the command passes through ST_CELL and then raises
// done, and the next command may be transferred in that same cycle. An out-of-range
// access gives its result with invalid set in the cycle after the transfer.
// Advance: done is high once ST_ADV has stepped through every active row, and the next
// command may be transferred in that same cycle. The row memory is read once per row,
// plus the last row again to seed the window, by a row of column cells that all shift
// one row per cycle; the memory read port sets that pace. The user must write
// active_rows and active_cols through the APB port only while busy is low; the block
// does not enforce this. Reset sets both sizes to 64 and marks every row as dead
// through its valid bit, so no clearing pass is needed and commands are taken right
// after reset.
`timescale 1ns / 1ps

module toroidal_life_grid_top
	import tlg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              in_item,
	output logic              done,
	output res_t              result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	state_t                 state_q;
	state_t                 state_d;
	logic [CNT_W-1:0]       k_q;
	cmd_t                   op_q;
	row_t                   save_q;
	logic                   done_q;
	res_t                   res_q;
	logic [SIZE_W-1:0]      rows_q;
	logic [SIZE_W-1:0]      cols_q;

	logic [SIZE_W-1:0]      nr;
	logic [SIZE_W-1:0]      nc;
	logic [ROW_W-1:0]       last_row;
	logic [COL_W-1:0]       last_col;
	logic [CNT_W-1:0]       adv_last;
	logic                   accept;
	logic                   in_ok;
	logic [ROW_W-1:0]       rd_addr;
	row_t                   row_word;
	row_t                   feed;
	row_t                   new_word;
	row_t                   cell_nxt;
	logic [MAX_COLS-1:0][2:0] cwin;
	logic                   shift;
	mem_wr_t                mem_wr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SIZE_W'(MAX_ROWS);
			cols_q <= SIZE_W'(MAX_COLS);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_ACTIVE_COLS) begin
				cols_q <= pwdata[SIZE_W-1:0];
			end else begin
				rows_q <= pwdata[SIZE_W-1:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACTIVE_ROWS) ? APB_DW'(rows_q) : APB_DW'(cols_q);

	// Effective sizes and the checks on an incoming command.
	assign nr       = clamp_size(rows_q, SIZE_W'(MAX_ROWS));
	assign nc       = clamp_size(cols_q, SIZE_W'(MAX_COLS));
	assign last_row = ROW_W'(nr - SIZE_W'(1));
	assign last_col = COL_W'(nc - SIZE_W'(1));
	assign adv_last = CNT_W'(nr) + CNT_W'(1);
	assign accept   = start && !busy;
	assign in_ok    = !in_item.row[7] && !in_item.col[7]
		&& (in_item.row[6:0] < nr)
		&& (in_item.col[6:0] < nc);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_item.kind == OP_ADVANCE) begin
						state_d = ST_ADV;
					end else if (in_ok) begin
						state_d = ST_CELL;
					end
				end
			end
			ST_CELL: begin
				state_d = ST_IDLE;
			end
			ST_ADV: begin
				if (k_q == adv_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs: handshake, memory addressing and the cell shift.
	always_comb begin
		busy    = 1'b1;
		rd_addr = op_q.row[ROW_W-1:0];
		shift   = 1'b0;
		mem_wr  = '0;
		case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				rd_addr = (in_item.kind == OP_ADVANCE) ? last_row : in_item.row[ROW_W-1:0];
			end
			ST_CELL: begin
				mem_wr.addr = op_q.row[ROW_W-1:0];
				mem_wr.data = row_word;
				mem_wr.data[op_q.col[COL_W-1:0]] = (op_q.kind == OP_REVIVE);
				mem_wr.en   = (op_q.kind == OP_KILL) || (op_q.kind == OP_REVIVE);
			end
			ST_ADV: begin
				rd_addr     = k_q[ROW_W-1:0];
				shift       = 1'b1;
				mem_wr.en   = (k_q >= CNT_W'(2));
				mem_wr.addr = ROW_W'(k_q - CNT_W'(2));
				mem_wr.data = new_word;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Row memory.
	tlg_row_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (mem_wr),
		.rd_data (row_word)
	);

	// The last fed row is row 0 again, taken from the copy saved before it was rewritten.
	assign feed = (k_q == adv_last) ? save_q : row_word;

	// Row of column cells, wrapping at the active column count.
	for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
		localparam int LeftIdx  = (c + MAX_COLS - 1) % MAX_COLS;
		localparam int RightIdx = (c + 1) % MAX_COLS;
		logic [2:0] left_w;
		logic [2:0] right_w;

		assign left_w  = (c == 0) ? cwin[last_col] : cwin[LeftIdx];
		assign right_w = (last_col == COL_W'(c)) ? cwin[0] : cwin[RightIdx];

		tlg_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.d       (feed[c]),
			.left_w  (left_w),
			.right_w (right_w),
			.win     (cwin[c]),
			.nxt     (cell_nxt[c])
		);
	end

	// Columns outside the active region keep their bits.
	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			new_word[c] = (SIZE_W'(c) < nc) ? cell_nxt[c] : cwin[c][1];
		end
	end

	// Controller state and counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (accept) begin
				k_q <= '0;
				if ((in_item.kind != OP_ADVANCE) && !in_ok) begin
					done_q <= 1'b1;
				end
			end else if (state_q == ST_ADV) begin
				k_q <= k_q + CNT_W'(1);
				if (k_q == adv_last) begin
					done_q <= 1'b1;
				end
			end else if (state_q == ST_CELL) begin
				done_q <= 1'b1;
			end
		end
	end

	// Command copy, saved row 0 and the result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= in_item;
			res_q      <= '{alive: 1'b0, invalid: (in_item.kind != OP_ADVANCE) && !in_ok};
		end else if (state_q == ST_CELL) begin
			res_q.alive   <= (op_q.kind == OP_QUERY) && row_word[op_q.col[COL_W-1:0]];
			res_q.invalid <= 1'b0;
		end else if (state_q == ST_ADV) begin
			res_q <= '0;
		end
		if ((state_q == ST_ADV) && (k_q == CNT_W'(1))) begin
			save_q <= row_word;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== design/tlg_checker.sv =====
// Port-level checker for the toroidal life grid, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlg_checker
	import tlg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t in_item,
	input logic done,
	input res_t result
);

	logic acc;
	logic acc_adv;

	assign acc     = start && !busy;
	assign acc_adv = acc && (in_item.kind == OP_ADVANCE);

	// A transferred command either keeps the block busy or answers at once.
	`TLG_ASSERT_NEXT(a_accept_reacts, acc, busy || done, "command transfer without reaction")
	// An advance never finishes at its transfer: the block stays busy with no result yet.
	`TLG_ASSERT_NEXT(a_adv_busy, acc_adv, busy && !done, "advance finished too early")
	// A live answer only comes from an in-range query.
	`TLG_ASSERT_SAME(a_alive_valid, done && result.alive, !result.invalid, "alive with invalid")
	// Leaving busy always delivers the command's result.
	`TLG_ASSERT_SAME(a_busy_done, $fell(busy), done, "busy dropped without a result")

endmodule

bind toroidal_life_grid_top tlg_checker u_tlg_checker (.*);
